// ----- src/assert_macros.svh -----
// assertion macros used by the page write sequencer core
// no dependencies; included by epws_core, which carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// ----- src/epws_pkg.sv -----
// types, codes and constants of the eeprom page write sequencer
// no dependencies; imported by epws_core and the top level
package epws_pkg;

	// memory and page geometry defaults; page size must be a power of two
	localparam int DEF_MEM_BYTES  = 32768;
	localparam int DEF_PAGE_BYTES = 64;

	localparam logic [15:0] SETTLE_RESET = 16'd10;
	localparam logic [7:0]  DEV_BASE     = 8'hA0;
	localparam logic [7:0]  DEV_CS_MASK  = 8'h0E;

	// configuration register indexes
	localparam logic [1:0] REG_DEVICE_ENABLED = 2'd0;
	localparam logic [1:0] REG_CHIP_SELECT    = 2'd1;
	localparam logic [1:0] REG_SETTLE_TICKS   = 2'd2;

	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_TICK     = 2'd1,
		OP_BUS_DONE = 2'd2
	} epws_op_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SETTLE = 2'd1,
		PH_BUS    = 2'd2
	} epws_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_BUSY  = 2'd1,
		ST_DONE  = 2'd2,
		ST_ERROR = 2'd3
	} epws_status_t;

	typedef struct packed {
		logic        device_enabled;
		logic [2:0]  chip_select;
		logic [15:0] settle_ticks;
	} epws_cfg_t;

	typedef struct packed {
		epws_op_t    operation;
		logic [15:0] start_address;
		logic [15:0] transfer_length;
		logic        bus_ok;
	} epws_item_t;

	typedef struct packed {
		epws_status_t status;
		logic         issue_write;
		logic [7:0]   device_byte;
		logic [15:0]  chunk_address;
		logic [6:0]   chunk_length;
		logic [15:0]  buffer_offset;
		logic         write_protect;
	} epws_result_t;

endpackage

// ----- src/epws_core.sv -----
// sequencer state and per-item decision logic of the page write sequencer
// depends on epws_pkg and assert_macros.svh
`include "assert_macros.svh"

module epws_core import epws_pkg::*; #(
	parameter int MEM_BYTES  = DEF_MEM_BYTES,
	parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  epws_item_t   item,
	input  epws_cfg_t    cfg,
	output epws_result_t res
);

	localparam int OFS_W = $clog2(PAGE_BYTES);
	localparam int CNT_W = $clog2(PAGE_BYTES + 1);
	localparam logic [16:0]      MEM_LIMIT = 17'(MEM_BYTES);
	localparam logic [CNT_W-1:0] PAGE_SIZE = CNT_W'(PAGE_BYTES);

	epws_phase_t      phase_q, phase_d;
	logic [15:0]      tick_q, tick_d;
	logic [15:0]      base_q, base_d;
	logic [15:0]      total_q, total_d;
	logic [15:0]      written_q, written_d;
	logic [CNT_W-1:0] pending_q, pending_d;
	logic             protect_q, protect_d;

	logic [16:0]      end_sum;
	logic             start_ok;
	logic [15:0]      tick_inc;
	logic             settle_done;
	logic [15:0]      mem_addr;
	logic [15:0]      remaining;
	logic [CNT_W-1:0] room;
	logic [CNT_W-1:0] chunk_n;
	logic             more;

	always_comb begin
		end_sum     = {1'b0, item.start_address} + {1'b0, item.transfer_length};
		start_ok    = (item.transfer_length != 16'd0) && (end_sum <= MEM_LIMIT);
		tick_inc    = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
		settle_done = tick_inc >= cfg.settle_ticks;
		mem_addr    = base_q + written_q;
		remaining   = total_q - written_q;
		// room left up to the next page boundary
		room        = PAGE_SIZE - CNT_W'(mem_addr[OFS_W-1:0]);
		chunk_n     = (remaining < 16'(room)) ? CNT_W'(remaining) : room;
		more        = written_q < total_q;
	end

	// next state
	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		base_d    = base_q;
		total_d   = total_q;
		written_d = written_q;
		pending_d = pending_q;
		protect_d = protect_q;
		if (item_valid && cfg.device_enabled) begin
			case (phase_q)
				PH_IDLE: begin
					if (item.operation == OP_START && start_ok) begin
						base_d    = item.start_address;
						total_d   = item.transfer_length;
						written_d = 16'd0;
						pending_d = '0;
						tick_d    = 16'd0;
						protect_d = 1'b1;
						phase_d   = PH_SETTLE;
					end
				end
				PH_SETTLE: begin
					if (item.operation == OP_TICK) begin
						tick_d = tick_inc;
						if (settle_done) begin
							if (more) begin
								pending_d = chunk_n;
								phase_d   = PH_BUS;
							end else begin
								protect_d = 1'b0;
								phase_d   = PH_IDLE;
							end
						end
					end
				end
				PH_BUS: begin
					if (item.operation == OP_BUS_DONE) begin
						if (item.bus_ok) begin
							written_d = written_q + 16'(pending_q);
							tick_d    = 16'd0;
							phase_d   = PH_SETTLE;
						end else begin
							protect_d = 1'b0;
							phase_d   = PH_IDLE;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// result of the item being decided
	always_comb begin
		res               = '0;
		res.device_byte   = DEV_BASE | ({4'b0, cfg.chip_select, 1'b0} & DEV_CS_MASK);
		res.write_protect = protect_d;
		if (!cfg.device_enabled) begin
			res.status = ST_ERROR;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					res.status = ST_IDLE;
					if (item.operation == OP_START)
						res.status = start_ok ? ST_BUSY : ST_ERROR;
				end
				PH_SETTLE: begin
					res.status = ST_BUSY;
					if (item.operation == OP_TICK && settle_done) begin
						if (more) begin
							res.issue_write   = 1'b1;
							res.chunk_address = mem_addr;
							res.chunk_length  = 7'(chunk_n);
							res.buffer_offset = written_q;
						end else begin
							res.status = ST_DONE;
						end
					end
				end
				PH_BUS: begin
					res.status = ST_BUSY;
					if (item.operation == OP_BUS_DONE && !item.bus_ok)
						res.status = ST_ERROR;
				end
				default: begin
					res.status = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= 16'd0;
			base_q    <= 16'd0;
			total_q   <= 16'd0;
			written_q <= 16'd0;
			pending_q <= '0;
			protect_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			base_q    <= base_d;
			total_q   <= total_d;
			written_q <= written_d;
			pending_q <= pending_d;
			protect_q <= protect_d;
		end
	end

	`ASSERT_AT(a_protect_follows_job, clk, arst_n, protect_q == (phase_q == PH_SETTLE || phase_q == PH_BUS))
	`ASSERT_NEVER(a_written_past_total, clk, arst_n, written_q > total_q)
	`ASSERT_AT(a_issue_enters_bus, clk, arst_n, item_valid && res.issue_write |=> phase_q == PH_BUS)
	`ASSERT_AT(a_chunk_in_page, clk, arst_n, item_valid && res.issue_write |-> chunk_n != '0 && chunk_n <= PAGE_SIZE)
	`ASSERT_AT(a_disabled_holds, clk, arst_n, item_valid && !cfg.device_enabled |=> $stable(phase_q) && $stable(written_q))

endmodule

// ----- src/eeprom_page_write_sequencer.sv -----
// top level of the eeprom page write sequencer: stream ports, config registers,
// input and result registers; depends on epws_pkg and epws_core
//
// Each input transfer (start, tick or bus finished) yields exactly one result
// transfer. A new item is taken every cycle while results drain. The input
// register is loaded by the input transfer; the item moves on to the result
// register when that one is free or drains, and its result is offered from there.
// The result register lets one more item enter while a result waits for tready;
// with both registers full the input stalls until m_tready comes back. Page size
// must be a power of two. Config writes are meant for idle periods only.

module eeprom_page_write_sequencer import epws_pkg::*; #(
	parameter int MEM_BYTES  = DEF_MEM_BYTES,
	parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // start_address, transfer_length, bus_ok, zero fill
	input  logic [1:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, issue_write, device_byte, chunk_address, chunk_length,
	// buffer_offset, write_protect, zero fill
	output logic [55:0] m_tdata
);

	epws_cfg_t    cfg_q;
	epws_item_t   item_s1;
	logic         valid_s1;
	epws_result_t res_s2;
	logic         valid_s2;
	epws_result_t res;
	logic         adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_enabled <= 1'b0;
			cfg_q.chip_select    <= 3'd0;
			cfg_q.settle_ticks   <= SETTLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_ENABLED: cfg_q.device_enabled <= cfg_data[0];
				REG_CHIP_SELECT:    cfg_q.chip_select    <= cfg_data[2:0];
				REG_SETTLE_TICKS:   cfg_q.settle_ticks   <= cfg_data;
				default: ;
			endcase
		end
	end

	// item moves into the result register when that one is free or drains
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (!valid_s2 || m_tready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation       <= epws_op_t'(s_tuser);
			item_s1.start_address   <= s_tdata[15:0];
			item_s1.transfer_length <= s_tdata[31:16];
			item_s1.bus_ok          <= s_tdata[32];
		end
		if (adv)
			res_s2 <= res;
	end

	epws_core #(
		.MEM_BYTES  (MEM_BYTES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (adv),
		.item       (item_s1),
		.cfg        (cfg_q),
		.res        (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, res_s2.write_protect, res_s2.buffer_offset, res_s2.chunk_length,
		res_s2.chunk_address, res_s2.device_byte, res_s2.issue_write, res_s2.status};

endmodule

// ----- bench/epws_result_checker.sv -----
// result checker for the eeprom page write sequencer: watches config writes and both
// stream channels, predicts each result and compares it field by field
// depends on epws_pkg
module epws_result_checker import epws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // start_address, transfer_length, bus_ok, zero fill
	input  logic [1:0]  s_tuser,   // operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	// status, issue_write, device_byte, chunk_address, chunk_length,
	// buffer_offset, write_protect, zero fill
	input  logic [55:0] m_tdata,
	output int          mismatches,
	output int          outstanding
);

	logic        dev_enabled;
	logic [2:0]  dev_select;
	logic [15:0] settle_limit;

	epws_phase_t seq_phase;
	logic [15:0] tick_count;
	logic [15:0] base_addr;
	logic [15:0] total_len;
	logic [15:0] written;
	logic [6:0]  pending_chunk;
	logic        protect_level;

	epws_result_t expected_results[$];

	function automatic epws_result_t compute_page_result(logic [1:0] op, logic [15:0] addr,
			logic [15:0] len, logic ok);
		epws_result_t r;
		int mem;
		int remain;
		int room;
		int n;
		r = '0;
		r.device_byte = DEV_BASE | ({4'd0, dev_select, 1'b0} & DEV_CS_MASK);
		if (!dev_enabled) begin
			r.status = ST_ERROR;
		end else begin
			case (seq_phase)
				PH_SETTLE: begin
					r.status = ST_BUSY;
					if (op == OP_TICK) begin
						if (tick_count != 16'hFFFF)
							tick_count = tick_count + 16'd1;
						if (tick_count >= settle_limit) begin
							if (written < total_len) begin
								mem = (int'(base_addr) + int'(written)) % 65536;
								remain = int'(total_len) - int'(written);
								room = DEF_PAGE_BYTES - (mem % DEF_PAGE_BYTES);
								n = (remain < room) ? remain : room;
								pending_chunk = n[6:0];
								r.issue_write = 1'b1;
								r.chunk_address = mem[15:0];
								r.chunk_length = n[6:0];
								r.buffer_offset = written;
								seq_phase = PH_BUS;
							end else begin
								r.status = ST_DONE;
								protect_level = 1'b0;
								seq_phase = PH_IDLE;
							end
						end
					end
				end
				PH_BUS: begin
					r.status = ST_BUSY;
					if (op == OP_BUS_DONE) begin
						if (ok) begin
							written = written + 16'(pending_chunk);
							tick_count = '0;
							seq_phase = PH_SETTLE;
						end else begin
							r.status = ST_ERROR;
							protect_level = 1'b0;
							seq_phase = PH_IDLE;
						end
					end
				end
				default: begin
					r.status = ST_IDLE;
					if (op == OP_START) begin
						if (len != 0 && int'(addr) + int'(len) <= DEF_MEM_BYTES) begin
							base_addr = addr;
							total_len = len;
							written = '0;
							pending_chunk = '0;
							tick_count = '0;
							protect_level = 1'b1;
							seq_phase = PH_SETTLE;
							r.status = ST_BUSY;
						end else begin
							r.status = ST_ERROR;
						end
					end
				end
			endcase
		end
		r.write_protect = protect_level;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic compare_field(string field, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
	endtask

	task automatic check_result();
		epws_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result transfer %0h with nothing expected", m_tdata));
		end else begin
			want = expected_results.pop_front();
			compare_field("status", 16'(m_tdata[1:0]), 16'(want.status));
			compare_field("issue_write", 16'(m_tdata[2]), 16'(want.issue_write));
			compare_field("device_byte", 16'(m_tdata[10:3]), 16'(want.device_byte));
			compare_field("chunk_address", m_tdata[26:11], want.chunk_address);
			compare_field("chunk_length", 16'(m_tdata[33:27]), 16'(want.chunk_length));
			compare_field("buffer_offset", m_tdata[49:34], want.buffer_offset);
			compare_field("write_protect", 16'(m_tdata[50]), 16'(want.write_protect));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_enabled = 1'b0;
			dev_select = '0;
			settle_limit = SETTLE_RESET;
			seq_phase = PH_IDLE;
			tick_count = '0;
			base_addr = '0;
			total_len = '0;
			written = '0;
			pending_chunk = '0;
			protect_level = 1'b0;
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEVICE_ENABLED: dev_enabled = cfg_data[0];
					REG_CHIP_SELECT:    dev_select = cfg_data[2:0];
					REG_SETTLE_TICKS:   settle_limit = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(compute_page_result(s_tuser, s_tdata[15:0],
					s_tdata[31:16], s_tdata[32]));
			if (m_tvalid && m_tready)
				check_result();
			outstanding = expected_results.size();
		end
	end

endmodule

// ----- bench/eeprom_page_write_sequencer_test.sv -----
// testbench top for the eeprom page write sequencer: clock, reset, config writes,
// page write job stimulus and receiver stalls; depends on epws_pkg, the block
// and epws_result_checker
module eeprom_page_write_sequencer_test;
	import epws_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int CYCLE_LIMIT = 100000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // start_address, transfer_length, bus_ok, zero fill
	logic [1:0]  s_tuser;   // operation
	logic        m_tvalid;
	logic        m_tready;
	// status, issue_write, device_byte, chunk_address, chunk_length,
	// buffer_offset, write_protect, zero fill
	logic [55:0] m_tdata;

	int mismatches;
	int outstanding;
	int send_idle_pct = 29;
	int recv_idle_pct = 29;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int settle_now = 10;
	int job_items;

	eeprom_page_write_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	epws_result_checker result_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when asked for
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = 60;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [15:0] len, logic ok);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, ok, len, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_config(logic en, logic [2:0] cs, logic [15:0] settle);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_DEVICE_ENABLED;
		cfg_data <= {15'd0, en};
		@(negedge clk);
		cfg_index <= REG_CHIP_SELECT;
		cfg_data <= {13'd0, cs};
		@(negedge clk);
		cfg_index <= REG_SETTLE_TICKS;
		cfg_data <= settle;
		@(negedge clk);
		cfg_we <= 1'b0;
		settle_now = settle;
	endtask

	// items the block ignores in the current busy phase
	task automatic send_noise(bit in_bus);
		case ($urandom_range(2))
			0: send_item(OP_START, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
			1: begin
				if (in_bus)
					send_item(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
				else
					send_item(OP_BUS_DONE, 16'($urandom), 16'($urandom),
						1'($urandom_range(1)));
			end
			default: begin
				if (in_bus)
					send_item(OP_RESERVED, 16'($urandom), 16'($urandom),
						1'($urandom_range(1)));
				else
					send_item(OP_START, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
			end
		endcase
	endtask

	// one start followed, when it is accepted, by the ticks and bus completions of its job
	task automatic run_job();
		int r;
		int need;
		int done_bytes;
		int mem;
		int chunk;
		logic [15:0] addr;
		logic [15:0] len;
		r = $urandom_range(99);
		if (r < 5) begin
			len = 16'd0;
			addr = 16'($urandom);
		end else if (r < 10) begin
			// end past the memory, reaches the top bits of both fields
			addr = 16'($urandom_range(16384, 65535));
			len = 16'($urandom_range(32768, 65535));
		end else if (r < 16) begin
			len = 16'($urandom_range(1, 130));
			addr = 16'(DEF_MEM_BYTES - int'(len));
		end else begin
			len = 16'($urandom_range(1, 150));
			addr = 16'($urandom_range(0, DEF_MEM_BYTES - int'(len)));
		end
		send_item(OP_START, addr, len, 1'($urandom_range(1)));
		job_items++;
		if (len == 0 || int'(addr) + int'(len) > DEF_MEM_BYTES)
			return;
		done_bytes = 0;
		forever begin
			need = (settle_now == 0) ? 1 : settle_now;
			repeat (need) begin
				if ($urandom_range(9) == 0)
					send_noise(1'b0);
				send_item(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
				job_items++;
			end
			if (done_bytes >= len)
				return;
			mem = (int'(addr) + done_bytes) % DEF_PAGE_BYTES;
			chunk = DEF_PAGE_BYTES - mem;
			if (int'(len) - done_bytes < chunk)
				chunk = int'(len) - done_bytes;
			if ($urandom_range(4) == 0)
				send_noise(1'b1);
			job_items++;
			if ($urandom_range(24) == 0) begin
				send_item(OP_BUS_DONE, 16'($urandom), 16'($urandom), 1'b0);
				return;
			end
			send_item(OP_BUS_DONE, 16'($urandom), 16'($urandom), 1'b1);
			done_bytes += chunk;
		end
	endtask

	initial begin
		int pass_n;
		logic en;
		logic [15:0] settle;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEVICE_ENABLED;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_START;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// still disabled after reset: every item answers error
		send_item(OP_START, 16'd0, 16'd1, 1'b1);
		send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 1'b0);
		send_item(OP_BUS_DONE, 16'd0, 16'd0, 1'b1);

		write_config(1'b1, 3'd7, 16'd0);
		send_item(OP_START, 16'd100, 16'd0, 1'b1);
		send_item(OP_START, 16'd32767, 16'd2, 1'b0);
		send_item(OP_START, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(OP_TICK, 16'd0, 16'd0, 1'b0);
		send_item(OP_BUS_DONE, 16'd0, 16'd0, 1'b1);
		send_item(OP_RESERVED, 16'd0, 16'd0, 1'b0);
		// job that crosses a page boundary
		send_item(OP_START, 16'd62, 16'd5, 1'b0);
		send_item(OP_START, 16'd0, 16'd1, 1'b1);
		send_item(OP_BUS_DONE, 16'd0, 16'd0, 1'b1);
		send_item(OP_TICK, 16'd0, 16'd0, 1'b0);
		send_item(OP_TICK, 16'd0, 16'd0, 1'b0);
		send_item(OP_RESERVED, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(OP_BUS_DONE, 16'd0, 16'd0, 1'b1);
		send_item(OP_TICK, 16'd0, 16'd0, 1'b0);
		send_item(OP_BUS_DONE, 16'd0, 16'd0, 1'b1);
		send_item(OP_TICK, 16'd0, 16'd0, 1'b0);
		// whole memory, aborted by a failed bus write
		send_item(OP_START, 16'd0, 16'd32768, 1'b0);
		send_item(OP_TICK, 16'd0, 16'd0, 1'b0);
		send_item(OP_BUS_DONE, 16'd0, 16'd0, 1'b0);
		// last page, ending exactly at the top of memory
		send_item(OP_START, 16'd32704, 16'd64, 1'b0);
		send_item(OP_TICK, 16'd0, 16'd0, 1'b0);
		send_item(OP_BUS_DONE, 16'd0, 16'd0, 1'b1);
		send_item(OP_TICK, 16'd0, 16'd0, 1'b0);

		// longest settle setting, then cut short by a smaller one mid-wait
		write_config(1'b1, 3'd0, 16'hFFFF);
		send_idle_pct = 0;
		send_item(OP_START, 16'd5, 16'd1, 1'b0);
		repeat (40)
			send_item(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
		write_config(1'b1, 3'd0, 16'd3);
		send_item(OP_TICK, 16'd0, 16'd0, 1'b0);
		send_item(OP_BUS_DONE, 16'd0, 16'd0, 1'b0);

		for (pass_n = 0; pass_n < 12; pass_n++) begin
			en = (pass_n != 5 && pass_n != 9);
			if (pass_n == 0)
				settle = 16'd0;
			else if (pass_n == 1)
				settle = 16'd1;
			else
				settle = 16'($urandom_range(0, 4));
			write_config(en, 3'($urandom_range(7)), settle);
			send_idle_pct = (pass_n == 3) ? 0 : 29;
			recv_idle_pct = (pass_n == 3) ? 0 : 29;
			if (pass_n == 2)
				hold_request = 1'b1;
			job_items = 0;
			if (!en) begin
				repeat (60)
					send_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
						1'($urandom_range(1)));
			end else begin
				while (job_items < 150)
					run_job();
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
